// ----- hdl/tnfd_pkg.sv -----
// tnfd_pkg: shared constants, types and reset state for the tar numeric field decoder
// used by tnfd_update, tnfd_finish and tar_numeric_field_decoder; no dependencies
package tnfd_pkg;

  // bytes kept for the result value and the longest field before a forced end
  localparam int RESULT_BYTES    = 8;
  localparam int MAX_FIELD_BYTES = 12;

  localparam int LANE_BITS = 8 * RESULT_BYTES;

  typedef logic [LANE_BITS-1:0] lane_t;

  // saturation bounds, sign-extended to 64 bits
  localparam logic [63:0] VAL_MAX = ~64'd0 >> (64 - LANE_BITS + 1);
  localparam logic [63:0] VAL_MIN = ~VAL_MAX;

  // octal overflow limits: accumulator bound divided by 8 and its low digit
  localparam lane_t      OCT_LIM_POS = LANE_BITS'(VAL_MAX >> 3);
  localparam lane_t      OCT_LIM_NEG = LANE_BITS'((VAL_MAX + 64'd1) >> 3);
  localparam logic [2:0] OCT_LOW_POS = 3'(VAL_MAX);
  localparam logic [2:0] OCT_LOW_NEG = 3'(VAL_MAX + 64'd1);

  localparam logic [3:0] MAX_BYTES_CNT = 4'(MAX_FIELD_BYTES);
  localparam logic [3:0] BYTES_SAT     = 4'hF;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] MARK_POS = 8'h80;
  localparam logic [7:0] MARK_NEG = 8'hFF;

  typedef enum logic [1:0] {
    OCT_SKIP   = 2'd0,
    OCT_DIGITS = 2'd1,
    OCT_DONE   = 2'd2
  } oct_phase_t;

  typedef enum logic [1:0] {
    CHK_SPACES = 2'd0,
    CHK_DIGITS = 2'd1,
    CHK_PAD    = 2'd2,
    CHK_MARKER = 2'd3
  } chk_phase_t;

  typedef struct packed {
    logic       first_pending;
    logic       binary_mode;
    oct_phase_t oct_phase;
    logic       negative;
    lane_t      acc;
    lane_t      window;
    logic [3:0] bytes_seen;
    logic       overflowed;
    chk_phase_t chk_phase;
    logic       chk_failed;
  } dec_state_t;

  localparam dec_state_t ST_RESET = '{
    first_pending: 1'b1,
    binary_mode:   1'b0,
    oct_phase:     OCT_SKIP,
    negative:      1'b0,
    acc:           '0,
    window:        '0,
    bytes_seen:    4'd0,
    overflowed:    1'b0,
    chk_phase:     CHK_SPACES,
    chk_failed:    1'b0
  };

  function automatic logic is_octal_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_SEVEN);
  endfunction

endpackage

// ----- hdl/tnfd_update.sv -----
// tnfd_update: per-byte state update (octal digit, base-256 shift, format check)
// depends on tnfd_pkg
module tnfd_update (
  input  tnfd_pkg::dec_state_t st_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output tnfd_pkg::dec_state_t st_o,
  output logic                 last_o
);

  tnfd_pkg::dec_state_t s;
  logic                 marker;
  logic                 digit;
  logic                 go;
  logic                 over;
  tnfd_pkg::lane_t      lim;
  logic [2:0]           lim_low;

  always_comb begin
    s       = st_i;
    digit   = tnfd_pkg::is_octal_digit(byte_i);
    marker  = st_i.first_pending &&
              (byte_i == tnfd_pkg::CH_NUL || byte_i == tnfd_pkg::MARK_POS ||
               byte_i == tnfd_pkg::MARK_NEG);
    go      = 1'b1;
    lim     = tnfd_pkg::OCT_LIM_POS;
    lim_low = tnfd_pkg::OCT_LOW_POS;
    over    = 1'b0;

    s.first_pending = 1'b0;

    if (st_i.first_pending && byte_i[7]) begin
      // base-256 marker byte: bit 6 is the sign, fill above with it
      s.binary_mode = 1'b1;
      s.negative    = byte_i[6];
      if (byte_i[6]) begin
        s.window = {{(tnfd_pkg::LANE_BITS-8){1'b1}}, byte_i};
      end else begin
        s.window = {{(tnfd_pkg::LANE_BITS-8){1'b0}}, 1'b0, byte_i[6:0]};
      end
    end else if (st_i.binary_mode) begin
      // byte shifted out at the top must be sign fill
      if (st_i.window[tnfd_pkg::LANE_BITS-1 -: 8] != {8{st_i.negative}}) begin
        s.overflowed = 1'b1;
      end
      s.window = {st_i.window[tnfd_pkg::LANE_BITS-9:0], byte_i};
    end else begin
      if (s.oct_phase == tnfd_pkg::OCT_SKIP) begin
        if (byte_i == tnfd_pkg::CH_SPACE || byte_i == tnfd_pkg::CH_TAB) begin
          go = 1'b0;
        end else begin
          s.oct_phase = tnfd_pkg::OCT_DIGITS;
          if (byte_i == tnfd_pkg::CH_MINUS) begin
            s.negative = 1'b1;
            go         = 1'b0;
          end
        end
      end
      if (s.negative) begin
        lim     = tnfd_pkg::OCT_LIM_NEG;
        lim_low = tnfd_pkg::OCT_LOW_NEG;
      end
      over = (s.acc > lim) || ((s.acc == lim) && (byte_i[2:0] > lim_low));
      if (go && s.oct_phase == tnfd_pkg::OCT_DIGITS) begin
        if (!digit) begin
          s.oct_phase = tnfd_pkg::OCT_DONE;
        end else if (over) begin
          s.overflowed = 1'b1;
          s.oct_phase  = tnfd_pkg::OCT_DONE;
        end else begin
          s.acc = {s.acc[tnfd_pkg::LANE_BITS-4:0], byte_i[2:0]};
        end
      end
    end

    // lenient format check
    if (marker) begin
      s.chk_phase = tnfd_pkg::CHK_MARKER;
    end
    case (s.chk_phase)
      tnfd_pkg::CHK_MARKER: begin
      end
      tnfd_pkg::CHK_SPACES: begin
        if (byte_i == tnfd_pkg::CH_SPACE) begin
        end else if (digit) begin
          s.chk_phase = tnfd_pkg::CHK_DIGITS;
        end else begin
          s.chk_phase = tnfd_pkg::CHK_PAD;
          if (byte_i != tnfd_pkg::CH_NUL) s.chk_failed = 1'b1;
        end
      end
      tnfd_pkg::CHK_DIGITS: begin
        if (!digit) begin
          s.chk_phase = tnfd_pkg::CHK_PAD;
          if (byte_i != tnfd_pkg::CH_SPACE && byte_i != tnfd_pkg::CH_NUL) begin
            s.chk_failed = 1'b1;
          end
        end
      end
      tnfd_pkg::CHK_PAD: begin
        if (byte_i != tnfd_pkg::CH_SPACE && byte_i != tnfd_pkg::CH_NUL) begin
          s.chk_failed = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (s.bytes_seen != tnfd_pkg::BYTES_SAT) begin
      s.bytes_seen = s.bytes_seen + 4'd1;
    end

    st_o   = s;
    last_o = last_i || (s.bytes_seen >= tnfd_pkg::MAX_BYTES_CNT);
  end

endmodule

// ----- hdl/tnfd_finish.sv -----
// tnfd_finish: forms the result value and flags from the final decoder state
// depends on tnfd_pkg
module tnfd_finish (
  input  tnfd_pkg::dec_state_t st_i,
  output logic signed [63:0]   value_o,
  output logic                 well_formed_o,
  output logic                 saturated_o,
  output logic                 binary_form_o
);

  logic        sign_bad;
  logic        ovf;
  logic [63:0] bin_val;
  logic [63:0] oct_val;
  logic [63:0] acc_ext;

  always_comb begin
    // kept bytes must carry the sign taken from the marker byte
    sign_bad = st_i.binary_mode &&
               (st_i.window[tnfd_pkg::LANE_BITS-1] != st_i.negative);
    ovf      = st_i.overflowed || sign_bad;
    bin_val  = 64'($signed(st_i.window));
    acc_ext  = 64'(st_i.acc);
    oct_val  = st_i.negative ? (64'd0 - acc_ext) : acc_ext;

    if (ovf) begin
      value_o = st_i.negative ? tnfd_pkg::VAL_MIN : tnfd_pkg::VAL_MAX;
    end else if (st_i.binary_mode) begin
      value_o = bin_val;
    end else begin
      value_o = oct_val;
    end
    well_formed_o = !st_i.chk_failed;
    saturated_o   = ovf;
    binary_form_o = st_i.binary_mode;
  end

endmodule

// ----- hdl/tar_numeric_field_decoder.sv -----
// tar_numeric_field_decoder: top level, input register, decode state and result register
// depends on tnfd_pkg, tnfd_update and tnfd_finish
//
// Decodes one tar header numeric field presented one byte per request, first byte
// first, with in_last_byte on the final byte; the field also ends on its twelfth byte.
// A first byte with bit 7 set selects base-256 two's complement, otherwise the field
// is octal with optional leading blanks and minus sign. One result request comes out
// per field: a signed 64-bit value saturated on overflow, plus well-formed, saturated
// and base-256 flags. The block takes one byte every clock cycle while in_stall is low;
// the last byte of a field waits in the input register while the state update forms
// the result, which the result register loads once it has room. Stalls on the result
// side only hold off the byte that ends the next field while the previous result is
// still waiting.
module tar_numeric_field_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_field_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_value,
  output logic               out_well_formed,
  output logic               out_saturated,
  output logic               out_binary_form
);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // running field state
  tnfd_pkg::dec_state_t st_r, st_nxt;
  tnfd_pkg::dec_state_t st_upd;
  logic                 field_end;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic signed [63:0] fin_value;
  logic               fin_well_formed;
  logic               fin_saturated;
  logic               fin_binary;

  logic s1_adv;
  logic in_take;
  logic out_load;

  tnfd_update u_update (
    .st_i   (st_r),
    .byte_i (s1_byte_r),
    .last_i (s1_last_r),
    .st_o   (st_upd),
    .last_o (field_end)
  );

  tnfd_finish u_finish (
    .st_i          (st_upd),
    .value_o       (fin_value),
    .well_formed_o (fin_well_formed),
    .saturated_o   (fin_saturated),
    .binary_form_o (fin_binary)
  );

  // a byte that closes a field needs room in the result register
  assign s1_adv   = s1_valid_r && (!field_end || !out_valid_r || !out_stall);
  assign out_load = s1_adv && field_end;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    st_nxt = st_r;
    if (s1_adv) begin
      // state returns to its reset value after each result
      st_nxt = field_end ? tnfd_pkg::ST_RESET : st_upd;
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      st_r        <= tnfd_pkg::ST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_field_byte;
      s1_last_r <= in_last_byte;
    end
    if (out_load) begin
      out_value       <= fin_value;
      out_well_formed <= fin_well_formed;
      out_saturated   <= fin_saturated;
      out_binary_form <= fin_binary;
    end
  end

  assign out_valid = out_valid_r;

endmodule
